FILE: hw/rtl/evol_pkg.sv
// evol_pkg: shared types, constants and register codes of the ewma volatility estimator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package evol_pkg;
  localparam int PRICE_WIDTH_DEF = 48;
  localparam int VOL_WIDTH_DEF   = 32;
  localparam int WORD_W          = 64;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int VAR_W           = 48;
  localparam int ALPHA_W         = 16;
  localparam int SCALE_W         = 26;
  localparam int FRAC_W          = 32;
  localparam int EXP_W           = 6;
  localparam int LOG_W           = EXP_W + FRAC_W;
  localparam int DIFF_W          = 33;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VOL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOL_FLOOR    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANNUAL_SCALE = 2'd3;

  localparam logic [ALPHA_W-1:0] RST_SMOOTHING    = 16'd9830;
  localparam logic [31:0]        RST_START_VOL    = 32'd3277;
  localparam logic [31:0]        RST_VOL_FLOOR    = 32'd1311;
  localparam logic [SCALE_W-1:0] RST_ANNUAL_SCALE = 26'd21772800;

  // ln 2 as Q0.31
  localparam logic [30:0] LN2_Q31 = 31'd1488522236;
  localparam logic [VAR_W-1:0] VAR_MAX = '1;

  typedef enum logic [1:0] {KIND_BAD, KIND_FIRST, KIND_UPDATE} evol_kind_t;

  typedef struct packed {
    evol_kind_t          kind;
    logic [WORD_W-1:0]   price;
  } evol_item_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } evol_cfg_wr_t;
endpackage

FILE: hw/rtl/evol_front.sv
// evol_front: accepts price requests and classifies them as bad, first or update
// depends on evol_pkg
`timescale 1ns / 1ps
module evol_front import evol_pkg::*; #(
  parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PRICE_WIDTH-1:0] price,
  output logic                   push,
  output evol_item_t             push_item,
  input  logic                   queue_full
);
  logic seen;
  logic zero;

  assign zero      = (price == '0);
  assign in_ready  = !queue_full;
  assign push      = in_valid && !queue_full;
  assign push_item.price = WORD_W'(price);
  assign push_item.kind  = zero ? KIND_BAD : (seen ? KIND_UPDATE : KIND_FIRST);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (push && !zero) begin
      seen <= 1'b1;
    end
  end
endmodule

FILE: hw/rtl/evol_queue.sv
// evol_queue: short request queue between front and back
// depends on evol_pkg
`timescale 1ns / 1ps
module evol_queue import evol_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  evol_item_t push_item,
  output logic       full,
  output logic       head_valid,
  output evol_item_t head_item,
  input  logic       pop
);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  evol_item_t       entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(do_pop);
    end
  end
endmodule

FILE: hw/rtl/evol_back.sv
// evol_back: sequencer for log2, ewma variance and square root, plus config and result registers
// depends on evol_pkg
`timescale 1ns / 1ps
module evol_back import evol_pkg::*; #(
  parameter int VOL_WIDTH = VOL_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  evol_cfg_wr_t       cfg,
  input  logic               head_valid,
  input  evol_item_t         head_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        volatility,
  output logic [VAR_W-1:0]   smoothed_variance,
  output logic               primed,
  output logic               bad_price
);
  localparam logic [31:0] VOL_MAX =
    (VOL_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << VOL_WIDTH) - 64'd1);

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_SQUARE, S_DIFF, S_RET, S_SQ, S_EW1, S_EW2,
    S_X1, S_X2, S_ROOT, S_VOL, S_DONE
  } state_t;

  state_t              state;
  evol_kind_t          kind;
  logic [ALPHA_W-1:0]  alpha;
  logic [31:0]         floor_vol;
  logic [SCALE_W-1:0]  scale;
  logic [WORD_W-1:0]   w;
  logic [EXP_W-1:0]    e;
  logic [2:0]          step;
  logic [4:0]          cnt;
  logic [31:0]         m;
  logic [FRAC_W-1:0]   frac;
  logic [LOG_W-1:0]    prev_log;
  logic [DIFF_W-1:0]   dreg;
  logic [DIFF_W-1:0]   r;
  logic [VAR_W-1:0]    sq;
  logic [WORD_W-1:0]   acc;
  logic [VAR_W-1:0]    var_acc;
  logic [WORD_W-1:0]   x;
  logic [WORD_W-1:0]   rt;
  logic [WORD_W-1:0]   bb;
  logic [31:0]         vol_est;
  logic                have_ref;

  logic [6:0]          norm_k;
  logic [WORD_W-1:0]   hi_mask;
  logic [63:0]         m_prod;
  logic [32:0]         m_top;
  logic [LOG_W-1:0]    la;
  logic [LOG_W-1:0]    d_full;
  logic [63:0]         ret_prod;
  logic [63:0]         sq_prod;
  logic [16:0]         one_minus;
  logic [WORD_W-1:0]   ew_sum;
  logic [WORD_W-1:0]   lo_prod;
  logic [WORD_W-1:0]   rt_try;
  logic [31:0]         v_floor;
  logic                emit;

  always_comb begin
    norm_k   = 7'd32 >> step;
    hi_mask  = ~({WORD_W{1'b1}} >> norm_k);
    m_prod   = m * m;
    m_top    = m_prod[63:31];
    la       = {e, frac};
    d_full   = (la >= prev_log) ? la - prev_log : prev_log - la;
    ret_prod = dreg * LN2_Q31;
    sq_prod  = r[31:0] * r[31:0];
    one_minus = 17'h10000 - 17'(alpha);
    ew_sum   = acc + one_minus * var_acc;
    lo_prod  = 64'(var_acc[15:0]) * 64'(scale);
    rt_try   = rt + bb;
    v_floor  = (rt[31:0] < floor_vol) ? floor_vol : rt[31:0];
    emit     = !out_valid || out_ready;
  end

  assign pop = (state == S_IDLE) && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      alpha     <= RST_SMOOTHING;
      floor_vol <= RST_VOL_FLOOR;
      scale     <= RST_ANNUAL_SCALE;
      vol_est   <= (RST_START_VOL > VOL_MAX) ? VOL_MAX : RST_START_VOL;
      var_acc   <= '0;
      prev_log  <= '0;
      have_ref  <= 1'b0;
      out_valid <= 1'b0;
      bad_price <= 1'b0;
    end else begin
      if (cfg.we) begin
        case (cfg.index)
          CFG_SMOOTHING:    alpha <= cfg.data[ALPHA_W-1:0];
          CFG_START_VOL:    vol_est <= (cfg.data > VOL_MAX) ? VOL_MAX : cfg.data;
          CFG_VOL_FLOOR:    floor_vol <= cfg.data;
          CFG_ANNUAL_SCALE: scale <= cfg.data[SCALE_W-1:0];
          default: ;
        endcase
      end
      // a waiting result leaves; S_DONE reloads the register itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            kind <= head_item.kind;
            w    <= head_item.price;
            e    <= EXP_W'(WORD_W - 1);
            step <= '0;
            state <= (head_item.kind == KIND_BAD) ? S_DONE : S_NORM;
          end
        end
        // leading-zero search, halving the window each cycle
        S_NORM: begin
          if ((w & hi_mask) == '0) begin
            w <= w << norm_k;
            e <= e - norm_k[EXP_W-1:0];
          end
          step <= step + 1'b1;
          if (step == 3'd5) begin
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          if (cnt == '0 && frac == '0 && m == '0) begin
            m <= w[63:32];
          end else begin
            frac <= {frac[FRAC_W-2:0], m_top[32]};
            m    <= m_top[32] ? m_top[32:1] : m_top[31:0];
            cnt  <= cnt + 1'b1;
            if (cnt == 5'd31) begin
              state <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          dreg     <= (d_full > LOG_W'({DIFF_W{1'b1}})) ? '1 : d_full[DIFF_W-1:0];
          prev_log <= la;
          if (kind == KIND_FIRST) begin
            have_ref <= 1'b1;
            state    <= S_DONE;
          end else begin
            state <= S_RET;
          end
        end
        S_RET: begin
          r     <= ret_prod[63:31];
          state <= S_SQ;
        end
        S_SQ: begin
          sq    <= r[32] ? VAR_MAX : sq_prod[63:16];
          state <= S_EW1;
        end
        S_EW1: begin
          acc   <= sq * alpha;
          state <= S_EW2;
        end
        S_EW2: begin
          var_acc <= ew_sum[63:16];
          state   <= S_X1;
        end
        S_X1: begin
          x     <= 64'(var_acc[47:16]) * 64'(scale);
          state <= S_X2;
        end
        S_X2: begin
          x     <= x + (lo_prod >> 16);
          rt    <= '0;
          bb    <= 64'd1 << 62;
          cnt   <= '0;
          state <= S_ROOT;
        end
        // one result bit per cycle
        S_ROOT: begin
          if (x >= rt_try) begin
            x  <= x - rt_try;
            rt <= (rt >> 1) + bb;
          end else begin
            rt <= rt >> 1;
          end
          bb  <= bb >> 2;
          cnt <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            state <= S_VOL;
          end
        end
        S_VOL: begin
          vol_est <= (v_floor > VOL_MAX) ? VOL_MAX : v_floor;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (emit) begin
            out_valid         <= 1'b1;
            volatility        <= vol_est;
            smoothed_variance <= var_acc;
            primed            <= have_ref;
            bad_price         <= (kind == KIND_BAD);
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_IDLE) begin
        cnt  <= '0;
        frac <= '0;
        m    <= '0;
      end
    end
  end
endmodule

FILE: hw/rtl/ewma_volatility_estimator.sv
// ewma_volatility_estimator: top level tying front, request queue and back
// depends on evol_pkg, evol_front, evol_queue, evol_back
// paths: a bad price goes straight to the result; a first price stops after log2; an update runs the full chain
// back: one request at a time, each held through the
//   32-step squaring log2 loop and the 32-step bit-serial square root
// reset: synchronous active-high rst clears queue and state, loads register defaults
`timescale 1ns / 1ps
module ewma_volatility_estimator import evol_pkg::*; #(
  parameter int PRICE_WIDTH = PRICE_WIDTH_DEF,
  parameter int VOL_WIDTH   = VOL_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PRICE_WIDTH-1:0] price,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            volatility,
  output logic [VAR_W-1:0]       smoothed_variance,
  output logic                   primed,
  output logic                   bad_price
);
  evol_cfg_wr_t cfg;
  logic         push;
  evol_item_t   push_item;
  logic         queue_full;
  logic         head_valid;
  evol_item_t   head_item;
  logic         pop;

  // config writes bundled for the back
  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // front: classifies each price request as bad, first or update
  evol_front #(.PRICE_WIDTH(PRICE_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_ready, .price,
    .push, .push_item, .queue_full
  );

  // queue lets input keep flowing while the back computes
  evol_queue u_queue (
    .clk, .rst, .push, .push_item, .full(queue_full),
    .head_valid, .head_item, .pop
  );

  // back: log2, ewma, annualize, square root, result register
  evol_back #(.VOL_WIDTH(VOL_WIDTH)) u_back (
    .clk, .rst, .cfg, .head_valid, .head_item, .pop,
    .out_valid, .out_ready, .volatility, .smoothed_variance, .primed, .bad_price
  );
endmodule
